// ===== design/grid_gradient_stencil_assert.svh =====
// Assertion macros used by ggs_stencil, the grid gradient stencil front end.
// Defining ASSERT_OFF turns every macro into an empty body.
`ifndef GRID_GRADIENT_STENCIL_ASSERT_SVH
`define GRID_GRADIENT_STENCIL_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication: cons must hold whenever ante holds.
`define GGS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid_gradient_stencil: assertion failed");
// Next-cycle implication: cons must hold in the cycle after ante holds.
`define GGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid_gradient_stencil: assertion failed");
`else
`define GGS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GGS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/ggs_pkg.sv =====
// Package of the grid gradient stencil: grid size, widths, register codes,
// the point record passed to the scaling units and the row store addressing.
// Depends on nothing.
package ggs_pkg;

   localparam int GRID_SIZE   = 64;
   localparam int COL_W       = $clog2(GRID_SIZE);
   localparam int STORE_DEPTH = 2 * GRID_SIZE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_SIZE - 1);

   localparam int SAMPLE_W = 32;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int INV_W    = 32;
   localparam int PROD_W   = DIFF_W + INV_W + 1;
   localparam int GRAD_W   = 40;
   localparam int IDX_W    = 10;
   localparam int TDATA_W  = 104;
   localparam int PAD_W    = TDATA_W - 2 * GRAD_W - 2 * IDX_W;

   localparam int SHIFT_ONE     = 24;
   localparam int SHIFT_CENTRAL = 25;

   localparam logic [INV_W-1:0] INV_RESET = 32'h0100_0000;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_X_SPACING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_Y_SPACING = 2'd1;

   // One grid point ready for scaling. A set half flag selects the central
   // difference, which takes one more bit of right shift.
   typedef struct packed {
      logic signed [DIFF_W-1:0] diff_x;
      logic signed [DIFF_W-1:0] diff_y;
      logic                     half_x;
      logic                     half_y;
      logic [COL_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic                     last;
   } point_type;

   // The two most recent rows live side by side, selected by row parity.
   function automatic logic [ADDR_W-1:0] store_addr(input logic par,
                                                    input logic [COL_W-1:0] col);
      logic [ADDR_W-1:0] base;
      base = par ? ADDR_W'(GRID_SIZE) : '0;
      return base + ADDR_W'(col);
   endfunction

endpackage

// ===== design/ggs_row_mem.sv =====
// Row store of the grid gradient stencil: one write port, two registered
// read ports, read-before-write on a shared address. Uses ggs_pkg.
module ggs_row_mem import ggs_pkg::*; (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr_a,
   input  logic [ADDR_W-1:0]   rd_addr_b,
   output logic [SAMPLE_W-1:0] rd_data_a,
   output logic [SAMPLE_W-1:0] rd_data_b
);

   logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
   logic [SAMPLE_W-1:0] rd_a_ff;
   logic [SAMPLE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== design/ggs_stencil.sv =====
// Stencil front end: raster counters, row store access, the column window
// and the sequencer that turns each sample into zero to three grid points.
// Uses ggs_pkg, ggs_row_mem and the assertion macros.
`include "grid_gradient_stencil_assert.svh"
module ggs_stencil import ggs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SAMPLE_W-1:0] in_sample,
   input  logic                en,
   output point_type           pt,
   output logic                pt_valid
);

   localparam logic [1:0] PT_MAIN = 2'd0;
   localparam logic [1:0] PT_TAIL = 2'd1;
   localparam logic [1:0] PT_END  = 2'd2;

   logic [COL_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                a_valid_ff, a_valid_in;
   logic [COL_W-1:0]    a_row_ff, a_col_ff;
   logic [SAMPLE_W-1:0] a_sample_ff;
   logic [1:0]          k_ff, k_in;
   logic [SAMPLE_W-1:0] w0_ff, w1_ff, h1_ff, h2_ff;
   point_type           pt_ff, pt_in;
   logic                pt_valid_ff;

   logic                accept, issue, retire;
   logic [1:0]          n;
   logic [ADDR_W-1:0]   wr_addr, rd_addr_a, rd_addr_b;
   logic [SAMPLE_W-1:0] rd_a, rd_b;

   function automatic logic signed [DIFF_W-1:0] sub(input logic [SAMPLE_W-1:0] a,
                                                    input logic [SAMPLE_W-1:0] b);
      return $signed({a[SAMPLE_W-1], a}) - $signed({b[SAMPLE_W-1], b});
   endfunction

   assign accept = in_valid && in_ready;

   // Reads for the accepted sample (r,c): port A fetches row r-1 one column
   // ahead, or row r column 0 at the end of a row; port B fetches row r-2.
   assign wr_addr   = store_addr(row_ff[0], col_ff);
   assign rd_addr_a = (col_ff == COL_LAST) ? store_addr(row_ff[0], '0)
                                           : store_addr(~row_ff[0], col_ff + 1'b1);
   assign rd_addr_b = store_addr(row_ff[0], col_ff);

   ggs_row_mem u_mem (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (wr_addr),
      .wr_data   (in_sample),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_comb begin
      if (a_row_ff == '0) begin
         n = 2'd0;
      end else if (a_row_ff == COL_LAST) begin
         if (a_col_ff == '0) begin
            n = 2'd1;
         end else if (a_col_ff == COL_LAST) begin
            n = 2'd3;
         end else begin
            n = 2'd2;
         end
      end else begin
         n = 2'd1;
      end
   end

   assign issue    = a_valid_ff && (n != 2'd0) && en;
   assign retire   = a_valid_ff && ((n == 2'd0) || (issue && (k_ff == n - 2'd1)));
   assign in_ready = !a_valid_ff || retire;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (retire) begin
         a_valid_in = 1'b0;
      end
      k_in = k_ff;
      if (retire) begin
         k_in = PT_MAIN;
      end else if (issue) begin
         k_in = k_ff + 2'd1;
      end
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_ff == COL_LAST) begin
            col_in = '0;
            row_in = (row_ff == COL_LAST) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // Window in stage A: w0 = (r-1,c-1), w1 = (r-1,c), rd_a = (r-1,c+1),
   // rd_b = (r-2,c), h1 = (r,c-1), h2 = (r,c-2).
   always_comb begin
      pt_in      = '0;
      pt_in.last = (k_ff == n - 2'd1);
      case (k_ff)
         PT_TAIL: begin
            pt_in.row    = COL_LAST;
            pt_in.col    = a_col_ff - 1'b1;
            pt_in.diff_y = sub(h1_ff, w0_ff);
            pt_in.half_y = 1'b0;
            if (a_col_ff == COL_W'(1)) begin
               pt_in.diff_x = sub(a_sample_ff, h1_ff);
               pt_in.half_x = 1'b0;
            end else begin
               pt_in.diff_x = sub(a_sample_ff, h2_ff);
               pt_in.half_x = 1'b1;
            end
         end
         PT_END: begin
            pt_in.row    = COL_LAST;
            pt_in.col    = COL_LAST;
            pt_in.diff_x = sub(a_sample_ff, h1_ff);
            pt_in.half_x = 1'b0;
            pt_in.diff_y = sub(a_sample_ff, w1_ff);
            pt_in.half_y = 1'b0;
         end
         default: begin
            pt_in.row = a_row_ff - 1'b1;
            pt_in.col = a_col_ff;
            if (a_col_ff == '0) begin
               pt_in.diff_x = sub(rd_a, w1_ff);
               pt_in.half_x = 1'b0;
            end else if (a_col_ff == COL_LAST) begin
               pt_in.diff_x = sub(w1_ff, w0_ff);
               pt_in.half_x = 1'b0;
            end else begin
               pt_in.diff_x = sub(rd_a, w0_ff);
               pt_in.half_x = 1'b1;
            end
            if (a_row_ff == COL_W'(1)) begin
               pt_in.diff_y = sub(a_sample_ff, w1_ff);
               pt_in.half_y = 1'b0;
            end else begin
               pt_in.diff_y = sub(a_sample_ff, rd_b);
               pt_in.half_y = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         a_valid_ff  <= 1'b0;
         k_ff        <= PT_MAIN;
         pt_valid_ff <= 1'b0;
      end else begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         a_valid_ff <= a_valid_in;
         k_ff       <= k_in;
         if (en) begin
            pt_valid_ff <= issue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_row_ff    <= row_ff;
         a_col_ff    <= col_ff;
         a_sample_ff <= in_sample;
      end
      if (retire) begin
         w0_ff <= w1_ff;
         w1_ff <= rd_a;
         h2_ff <= h1_ff;
         h1_ff <= a_sample_ff;
      end
      if (issue) begin
         pt_ff <= pt_in;
      end
   end

   assign pt       = pt_ff;
   assign pt_valid = pt_valid_ff;

   `GGS_ASSERT_IMPL(a_rd_wr_apart, clock, reset, accept, rd_addr_a != wr_addr)
   `GGS_ASSERT_IMPL(a_k_in_range, clock, reset, a_valid_ff && (n != 2'd0), k_ff < n)
   `GGS_ASSERT_NEXT(a_col_wrap, clock, reset, accept && (col_ff == COL_LAST), col_ff == '0)
   `GGS_ASSERT_NEXT(a_issue_valid, clock, reset, issue, pt_valid_ff)

endmodule

// ===== design/ggs_scale.sv =====
// Scaling unit: multiplies a difference by a Q8.24 reciprocal, shifts it
// right arithmetically by 24 or 25 and saturates to 40 bits. Uses ggs_pkg.
module ggs_scale import ggs_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [DIFF_W-1:0] diff,
   input  logic                     half,
   input  logic [INV_W-1:0]         inv,
   output logic signed [GRAD_W-1:0] result
);

   localparam logic signed [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
   localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     half_ff;
   logic signed [GRAD_W-1:0] res_ff, res_in;
   logic signed [PROD_W-1:0] q;

   assign prod_in = PROD_W'(diff * $signed({1'b0, inv}));

   // The arithmetic shift floors, which matches rounding a negative
   // magnitude up before negating it.
   always_comb begin
      q = half_ff ? (prod_ff >>> SHIFT_CENTRAL) : (prod_ff >>> SHIFT_ONE);
      if (q > PROD_W'(GRAD_MAX)) begin
         res_in = GRAD_MAX;
      end else if (q < PROD_W'(GRAD_MIN)) begin
         res_in = GRAD_MIN;
      end else begin
         res_in = q[GRAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         half_ff <= half;
         res_ff  <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// ===== design/grid_gradient_stencil.sv =====
// grid_gradient_stencil: x and y gradient of a 64 x 64 grid of signed 32-bit
// samples that arrive in raster order on the req_ stream. Interior points
// use the central difference, edge points the one-sided difference; each
// difference is multiplied by the Q8.24 reciprocal spacing from the csr_
// port, shifted right arithmetically by 24 (25 for central) and saturated to
// signed 40 bits. Row 0 produces no results. Sample (r,c) with r >= 1 yields
// point (r-1,c); in the last row each sample after column 0 also yields
// point (63,c-1), and the final sample yields (63,63) as well, so rsp_tlast
// marks the last result of each sample. The single scaling pipeline takes
// one point per cycle while the result stage is not stalled, and the
// sequencer holds each sample until all its points have gone in. The first
// result of a sample passes through the sample register, the point
// register, the product stage and the result stage, and the extra last-row
// results follow it in order. The two most recent rows sit in a 128-entry
// row store with two registered read ports; the raster order never uses an
// entry before writing it, so there is no clearing pass after reset. The
// csr_ port is always ready; write it only while the block is idle.
module grid_gradient_stencil import ggs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // req_tdata: path_sample [31:0]
   input  logic [SAMPLE_W-1:0]  req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // rsp_tdata: grad_x [39:0], grad_y [79:40], out_row [89:80],
   // out_col [99:90], zero padding [103:100]
   output logic [TDATA_W-1:0]   rsp_tdata,
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [INV_W-1:0]     csr_data
);

   logic [INV_W-1:0] inv_x_ff, inv_y_ff;
   logic             csr_we;

   // Pipeline after the sequencer: point register, product stage, result
   // stage. The whole pipe moves together whenever the result stage is
   // empty or being taken.
   logic             en;
   point_type        pt;
   logic             pt_valid;
   logic             v1_ff, v2_ff;
   logic [COL_W-1:0] row1_ff, col1_ff, row2_ff, col2_ff;
   logic             last1_ff, last2_ff;

   logic signed [GRAD_W-1:0] grad_x, grad_y;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_x_ff <= INV_RESET;
         inv_y_ff <= INV_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INV_X_SPACING: inv_x_ff <= csr_data;
            CSR_INV_Y_SPACING: inv_y_ff <= csr_data;
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   assign en = !v2_ff || rsp_tready;

   ggs_stencil u_stencil (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sample (req_tdata),
      .en        (en),
      .pt        (pt),
      .pt_valid  (pt_valid)
   );

   ggs_scale u_scale_x (
      .clock  (clock),
      .en     (en),
      .diff   (pt.diff_x),
      .half   (pt.half_x),
      .inv    (inv_x_ff),
      .result (grad_x)
   );

   ggs_scale u_scale_y (
      .clock  (clock),
      .en     (en),
      .diff   (pt.diff_y),
      .half   (pt.half_y),
      .inv    (inv_y_ff),
      .result (grad_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= pt_valid;
         v2_ff <= v1_ff;
      end
   end

   // Point coordinates travel beside the scaling stages.
   always_ff @(posedge clock) begin
      if (en) begin
         row1_ff  <= pt.row;
         col1_ff  <= pt.col;
         last1_ff <= pt.last;
         row2_ff  <= row1_ff;
         col2_ff  <= col1_ff;
         last2_ff <= last1_ff;
      end
   end

   assign rsp_tvalid = v2_ff;
   assign rsp_tlast  = last2_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, IDX_W'(col2_ff), IDX_W'(row2_ff), grad_y, grad_x};

endmodule

// ===== verif/grid_gradient_checker.sv =====
// Scoreboard for the grid gradient stencil: tracks the raster position and the
// two most recent rows, predicts every gradient result and compares it on rsp_.
// Depends on ggs_pkg for the grid size, the field widths and the register codes.
module grid_gradient_checker import ggs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [SAMPLE_W-1:0]  req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [TDATA_W-1:0]   rsp_tdata,
   input  logic                 rsp_tlast,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [INV_W-1:0]     csr_data,
   output int                   errors,
   output int                   pending
);

   localparam longint GRAD_HI = 64'sd549755813887;
   localparam longint GRAD_LO = -64'sd549755813888;

   typedef struct {
      logic [GRAD_W-1:0] grad_x;
      logic [GRAD_W-1:0] grad_y;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic              last;
   } grad_point_type;

   grad_point_type expected_points [$];

   logic signed [SAMPLE_W-1:0] rows_seen [STORE_DEPTH];
   logic [COL_W-1:0]           next_row;
   logic [COL_W-1:0]           next_col;
   logic [COL_W-1:0]           cur_row;
   logic [COL_W-1:0]           cur_col;
   logic signed [SAMPLE_W-1:0] cur_sample;
   logic [INV_W-1:0]           inv_x;
   logic [INV_W-1:0]           inv_y;
   int                         fail_count = 0;

   // The sample being accepted is not yet in the store, so it is read directly.
   function automatic logic signed [SAMPLE_W-1:0] sample_at(input logic [COL_W-1:0] r,
                                                            input logic [COL_W-1:0] c);
      if (r == cur_row && c == cur_col)
         return cur_sample;
      return rows_seen[{r[0], c}];
   endfunction

   // Exact signed product, arithmetic shift (floor), then clamp to 40 bits.
   function automatic logic [GRAD_W-1:0] grad_scale(input logic signed [DIFF_W-1:0] diff,
                                                    input logic [INV_W-1:0] inv,
                                                    input logic central);
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] q;
      prod = diff * $signed({1'b0, inv});
      q = central ? (prod >>> SHIFT_CENTRAL) : (prod >>> SHIFT_ONE);
      if (q > GRAD_HI)
         return GRAD_HI[GRAD_W-1:0];
      if (q < GRAD_LO)
         return GRAD_LO[GRAD_W-1:0];
      return q[GRAD_W-1:0];
   endfunction

   function automatic grad_point_type grade_point(input logic [COL_W-1:0] pr,
                                                  input logic [COL_W-1:0] pc);
      grad_point_type           p;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic                     central_x;
      logic                     central_y;
      central_x = (pc != '0) && (pc != COL_LAST);
      central_y = (pr != '0) && (pr != COL_LAST);
      if (pc == '0)
         dx = sample_at(pr, COL_W'(1)) - sample_at(pr, COL_W'(0));
      else if (pc == COL_LAST)
         dx = sample_at(pr, COL_LAST) - sample_at(pr, COL_LAST - 1'b1);
      else
         dx = sample_at(pr, pc + 1'b1) - sample_at(pr, pc - 1'b1);
      if (pr == '0)
         dy = sample_at(COL_W'(1), pc) - sample_at(COL_W'(0), pc);
      else if (pr == COL_LAST)
         dy = sample_at(COL_LAST, pc) - sample_at(COL_LAST - 1'b1, pc);
      else
         dy = sample_at(pr + 1'b1, pc) - sample_at(pr - 1'b1, pc);
      p.grad_x = grad_scale(dx, inv_x, central_x);
      p.grad_y = grad_scale(dy, inv_y, central_y);
      p.row    = IDX_W'(pr);
      p.col    = IDX_W'(pc);
      p.last   = 1'b0;
      return p;
   endfunction

   task automatic predict_sample(input logic [SAMPLE_W-1:0] sample);
      grad_point_type due [3];
      int             n;
      n = 0;
      cur_row    = next_row;
      cur_col    = next_col;
      cur_sample = sample;
      if (cur_row != '0) begin
         due[n] = grade_point(cur_row - 1'b1, cur_col);
         n++;
      end
      if (cur_row == COL_LAST && cur_col != '0) begin
         due[n] = grade_point(COL_LAST, cur_col - 1'b1);
         n++;
      end
      if (cur_row == COL_LAST && cur_col == COL_LAST) begin
         due[n] = grade_point(COL_LAST, COL_LAST);
         n++;
      end
      if (n > 0)
         due[n-1].last = 1'b1;
      for (int i = 0; i < n; i++)
         expected_points.push_back(due[i]);
      rows_seen[{cur_row[0], cur_col}] = sample;
      if (cur_col == COL_LAST) begin
         next_col = '0;
         next_row = (cur_row == COL_LAST) ? '0 : cur_row + 1'b1;
      end else begin
         next_col = cur_col + 1'b1;
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      grad_point_type want;
      if (expected_points.size() == 0) begin
         fail_count++;
         $display("%0t: result with none expected, expected nothing got %h", $time, rsp_tdata);
      end else begin
         want = expected_points.pop_front();
         check_field("grad_x", 64'(want.grad_x), 64'(rsp_tdata[GRAD_W-1:0]));
         check_field("grad_y", 64'(want.grad_y), 64'(rsp_tdata[2*GRAD_W-1:GRAD_W]));
         check_field("out_row", 64'(want.row), 64'(rsp_tdata[2*GRAD_W+IDX_W-1:2*GRAD_W]));
         check_field("out_col", 64'(want.col),
                     64'(rsp_tdata[2*GRAD_W+2*IDX_W-1:2*GRAD_W+IDX_W]));
         check_field("last", 64'(want.last), 64'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         next_row = '0;
         next_col = '0;
         inv_x    = INV_RESET;
         inv_y    = INV_RESET;
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INV_X_SPACING: inv_x = csr_data;
               CSR_INV_Y_SPACING: inv_y = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (req_tvalid && req_tready)
            predict_sample(req_tdata);
      end
      pending <= expected_points.size();
      errors  <= fail_count;
   end

endmodule

// ===== verif/grid_gradient_stencil_tb.sv =====
// Top of the grid gradient stencil testbench: clock, reset, sample and register
// stimulus, random back-pressure on the result stream, watchdog and verdict.
// Depends on ggs_pkg, grid_gradient_stencil and grid_gradient_checker.
module grid_gradient_stencil_tb;
   import ggs_pkg::*;

   // A short run over the first rows of the grid, split into several phases
   // with different spacing settings.
   localparam int TOTAL_SAMPLES  = 280;
   localparam int DIRECTED_COUNT = 25;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 2000;

   // Indexes past the two spacing registers must be ignored by the block.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam logic [INV_W-1:0] INV_MAX  = 32'hFFFF_FFFF;
   localparam logic [INV_W-1:0] INV_ZERO = 32'h0000_0000;
   localparam logic [INV_W-1:0] INV_ONE  = 32'h0000_0001;

   // Extremes of the sample range and values near zero; the first four alternate
   // so that neighbors differ by the largest amount in both directions.
   localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [12] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000,
      32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF
   };

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [SAMPLE_W-1:0]  req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [TDATA_W-1:0]   rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [INV_W-1:0]     csr_data   = '0;

   int          errors;
   int          pending;
   int          idle_cycles = 0;
   int unsigned stall_left  = 0;
   // When set, neither side inserts gaps: back-to-back traffic.
   bit          steady      = 1'b0;

   grid_gradient_stencil u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   grid_gradient_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .errors     (errors),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) < 88)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // A mix of full-range values (every bit toggles), the range extremes that
   // drive the scaling into saturation, and small values where the rounding
   // toward minus infinity of the shift is visible.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return $urandom;
      if (roll < 65) begin
         case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return 32'($urandom_range(0, 200)) - 32'd100;
   endfunction

   // Offer one sample and hold it until the block takes it. tvalid is only
   // lowered when a gap is wanted, so back-to-back requests keep it high.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      int unsigned gap;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 35)
         gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [INV_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending and wait for every outstanding result. Samples of row 0
   // produce nothing, so a further DRAIN_CYCLES wait covers the pipeline.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Spacings rotate per phase: reset, the largest reciprocal (saturation), zero,
   // random values, the smallest nonzero step, and mixed ones.
   task automatic set_spacing(input int phase);
      case (phase % 6)
         0: begin
            write_csr(CSR_INV_X_SPACING, INV_RESET);
            write_csr(CSR_INV_Y_SPACING, INV_RESET);
         end
         1: begin
            write_csr(CSR_INV_X_SPACING, INV_MAX);
            write_csr(CSR_INV_Y_SPACING, INV_MAX);
         end
         2: begin
            write_csr(CSR_INV_X_SPACING, INV_ZERO);
            write_csr(CSR_INV_Y_SPACING, INV_ZERO);
            write_csr(CSR_SPARE_LO, $urandom);
            write_csr(CSR_SPARE_HI, $urandom);
         end
         3: begin
            write_csr(CSR_INV_X_SPACING, $urandom);
            write_csr(CSR_INV_Y_SPACING, $urandom);
         end
         4: begin
            write_csr(CSR_INV_X_SPACING, INV_ONE);
            write_csr(CSR_INV_Y_SPACING, INV_ONE);
         end
         default: begin
            write_csr(CSR_INV_X_SPACING, INV_RESET >> 1);
            write_csr(CSR_INV_Y_SPACING, $urandom);
         end
      endcase
   endtask

   // The result side stalls at random, with stretches of no stalling while
   // the steady flag is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 99) < 25) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Counts cycles in which no request, result or register write moves.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int sent;
      int phase;
      int span;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening under the reset spacing: the edge samples first, then
      // random values to fill the rest of the opening stretch of row 0.
      for (int i = 0; i < 12; i++)
         send_sample(EDGE_SAMPLES[i]);
      for (int i = 12; i < DIRECTED_COUNT; i++)
         send_sample(pick_sample());
      sent  = DIRECTED_COUNT;
      phase = 0;

      // Random phases. The first continues under the reset spacing without a
      // pause; each later one first drains the block completely, then picks a
      // new spacing. Every fourth phase runs without any idling.
      while (sent < TOTAL_SAMPLES) begin
         if (phase != 0) begin
            settle();
            set_spacing(phase);
         end
         steady = (phase % 4 == 3);
         span   = $urandom_range(40, 80);
         if (span > TOTAL_SAMPLES - sent)
            span = TOTAL_SAMPLES - sent;
         repeat (span) send_sample(pick_sample());
         sent  += span;
         phase++;
      end

      steady = 1'b0;
      settle();
      if (errors == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
